FILE: hw/rtl/ppo_pkg.sv
// ----------------------------------------------------------------------------
// ppo_pkg
// Shared constants and types for the perspective projection / outcode block.
// ----------------------------------------------------------------------------
package ppo_pkg;

   localparam int NUM_W     = 47;
   localparam int DIV_W     = 31;
   localparam int DIV_STEPS = NUM_W;
   localparam int CSR_AW    = 5;
   localparam int REQ_W     = 128;
   localparam int RSP_W     = 208;
   localparam int CODE_W    = 10;
   localparam int MAG_W     = 41;

   localparam logic [2:0] REG_NEAR_Z      = 3'd0;
   localparam logic [2:0] REG_FOG_END     = 3'd1;
   localparam logic [2:0] REG_FAR_Z       = 3'd2;
   localparam logic [2:0] REG_PERSP_SCALE = 3'd3;
   localparam logic [2:0] REG_RHW_SCALE   = 3'd4;
   localparam logic [2:0] REG_CENTER_XY   = 3'd5;
   localparam logic [2:0] REG_CLIP_X_WIN  = 3'd6;
   localparam logic [2:0] REG_CLIP_Y_WIN  = 3'd7;

   localparam logic [30:0] RST_NEAR_Z      = 31'd65536;
   localparam logic [30:0] RST_FOG_END     = 31'd1342177280;
   localparam logic [30:0] RST_FAR_Z       = 31'd1342177280;
   localparam logic [30:0] RST_PERSP_SCALE = 31'd33554432;
   localparam logic [30:0] RST_RHW_SCALE   = 31'd65536;
   localparam logic [31:0] RST_CENTER_XY   = 32'd15729040;
   localparam logic [31:0] RST_CLIP_X_WIN  = 32'd41943040;
   localparam logic [31:0] RST_CLIP_Y_WIN  = 32'd31457280;

   localparam logic [CODE_W-1:0] CODE_NEAR = 10'h380;
   localparam logic [MAG_W-1:0]  MAG_CAP   = 41'h100_0000_0000;

   typedef struct packed {
      logic [31:0] cam_x;
      logic [31:0] cam_y;
      logic [31:0] cam_z;
      logic [31:0] rhw_in;
      logic        last;
      logic        near;
      logic        far;
   } side_type;

endpackage

FILE: hw/rtl/perspective_project_outcode.sv
// ----------------------------------------------------------------------------
// perspective_project_outcode
// Projects camera-space vertices to screen space with near/far handling and
// left/right/top/bottom clip outcodes.
// ----------------------------------------------------------------------------
// channel  ports          direction  contents
// req      req_t*         in         camera vertex, tlast = end of mesh
// rsp      rsp_t*         out        projected vertex, tlast = end of mesh
// csr      csr_p*         in/out     register file, 8 words
//
// one vertex per cycle while req_tready is high
// path is input capture, the 47-step radix-2 divider pipeline, 4 math stages
// reset clears all valid bits and loads register defaults
// a result waiting on rsp parks in a one-entry skid stage; req_tready
// drops only while that skid stage is full, then the whole pipeline holds
// ----------------------------------------------------------------------------
module perspective_project_outcode
   import ppo_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // cam_x, cam_y, cam_z, rhw_in
   input  logic [REQ_W-1:0]  req_tdata,
   input  logic              req_tlast,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // screen_x, screen_y, depth_out, rhw_out, tex_u, tex_v, clip_code, zero pad
   output logic [RSP_W-1:0]  rsp_tdata,
   output logic              rsp_tlast,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   // registers
   logic [30:0] near_z_ff, fog_end_ff, far_z_ff, persp_scale_ff, rhw_scale_ff;
   logic [31:0] center_xy_ff, clip_x_win_ff, clip_y_win_ff;

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         near_z_ff      <= RST_NEAR_Z;
         fog_end_ff     <= RST_FOG_END;
         far_z_ff       <= RST_FAR_Z;
         persp_scale_ff <= RST_PERSP_SCALE;
         rhw_scale_ff   <= RST_RHW_SCALE;
         center_xy_ff   <= RST_CENTER_XY;
         clip_x_win_ff  <= RST_CLIP_X_WIN;
         clip_y_win_ff  <= RST_CLIP_Y_WIN;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_paddr[4:2])
            REG_NEAR_Z:      near_z_ff      <= csr_pwdata[30:0];
            REG_FOG_END:     fog_end_ff     <= csr_pwdata[30:0];
            REG_FAR_Z:       far_z_ff       <= csr_pwdata[30:0];
            REG_PERSP_SCALE: persp_scale_ff <= csr_pwdata[30:0];
            REG_RHW_SCALE:   rhw_scale_ff   <= csr_pwdata[30:0];
            REG_CENTER_XY:   center_xy_ff   <= csr_pwdata;
            REG_CLIP_X_WIN:  clip_x_win_ff  <= csr_pwdata;
            REG_CLIP_Y_WIN:  clip_y_win_ff  <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[4:2])
         REG_NEAR_Z:      csr_prdata = {1'b0, near_z_ff};
         REG_FOG_END:     csr_prdata = {1'b0, fog_end_ff};
         REG_FAR_Z:       csr_prdata = {1'b0, far_z_ff};
         REG_PERSP_SCALE: csr_prdata = {1'b0, persp_scale_ff};
         REG_RHW_SCALE:   csr_prdata = {1'b0, rhw_scale_ff};
         REG_CENTER_XY:   csr_prdata = center_xy_ff;
         REG_CLIP_X_WIN:  csr_prdata = clip_x_win_ff;
         REG_CLIP_Y_WIN:  csr_prdata = clip_y_win_ff;
         default:         csr_prdata = '0;
      endcase
   end

   // pipeline control
   logic adv;
   logic skid_vld_ff, skid_vld_in, rsp_vld_ff, rsp_vld_in;

   assign adv        = !skid_vld_ff;
   assign req_tready = adv;

   // divider pipeline, stage 0 is the input capture
   logic [DIV_STEPS:0] vld_ff;
   logic [DIV_W-1:0]   rem_ff [0:DIV_STEPS];
   logic [DIV_W-1:0]   rem_in [0:DIV_STEPS];
   logic [NUM_W-1:0]   nq_ff  [0:DIV_STEPS];
   logic [NUM_W-1:0]   nq_in  [0:DIV_STEPS];
   logic [DIV_W-1:0]   dvs_ff [0:DIV_STEPS];
   logic [DIV_W-1:0]   dvs_in [0:DIV_STEPS];
   side_type           side_ff [0:DIV_STEPS];
   side_type           side_in [0:DIV_STEPS];

   always_comb begin
      logic [DIV_W:0] trial;
      logic           ge;
      trial = '0;
      ge    = 1'b0;
      side_in[0].cam_x  = req_tdata[31:0];
      side_in[0].cam_y  = req_tdata[63:32];
      side_in[0].cam_z  = req_tdata[95:64];
      side_in[0].rhw_in = req_tdata[127:96];
      side_in[0].last   = req_tlast;
      side_in[0].near   = $signed(req_tdata[95:64]) < $signed({1'b0, near_z_ff});
      side_in[0].far    = $signed(req_tdata[95:64]) > $signed({1'b0, fog_end_ff});
      rem_in[0] = '0;
      nq_in[0]  = {persp_scale_ff, 16'b0};
      dvs_in[0] = (req_tdata[94:64] == 31'd0) ? DIV_W'(1) : req_tdata[94:64];
      for (int k = 1; k <= DIV_STEPS; k++) begin
         trial = {rem_ff[k-1], nq_ff[k-1][NUM_W-1]};
         ge    = trial >= {1'b0, dvs_ff[k-1]};
         rem_in[k]  = ge ? DIV_W'(trial - {1'b0, dvs_ff[k-1]}) : trial[DIV_W-1:0];
         nq_in[k]   = {nq_ff[k-1][NUM_W-2:0], ge};
         dvs_in[k]  = dvs_ff[k-1];
         side_in[k] = side_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k <= DIV_STEPS; k++) begin
            rem_ff[k]  <= rem_in[k];
            nq_ff[k]   <= nq_in[k];
            dvs_ff[k]  <= dvs_in[k];
            side_ff[k] <= side_in[k];
         end
      end
   end

   // m0: magnitudes
   logic             m0_vld_ff;
   side_type         m0_side_ff;
   logic [NUM_W-1:0] m0_scale_ff;
   logic [31:0]      m0_magx_ff, m0_magy_ff, m0_magx_in, m0_magy_in;
   logic             m0_negx_ff, m0_negy_ff;

   assign m0_magx_in = side_ff[DIV_STEPS].cam_x[31] ?
                       (~side_ff[DIV_STEPS].cam_x + 32'd1) : side_ff[DIV_STEPS].cam_x;
   assign m0_magy_in = side_ff[DIV_STEPS].cam_y[31] ?
                       (~side_ff[DIV_STEPS].cam_y + 32'd1) : side_ff[DIV_STEPS].cam_y;

   // m1: partial products
   logic        m1_vld_ff;
   side_type    m1_side_ff;
   logic        m1_negx_ff, m1_negy_ff;
   logic [63:0] m1_xlo_ff, m1_ylo_ff, m1_xlo_in, m1_ylo_in;
   logic [46:0] m1_xhi_ff, m1_yhi_ff, m1_xhi_in, m1_yhi_in;
   logic [62:0] m1_rlo_ff, m1_rlo_in;
   logic [45:0] m1_rhi_ff, m1_rhi_in;

   assign m1_xlo_in = {32'b0, m0_scale_ff[31:0]} * {32'b0, m0_magx_ff};
   assign m1_ylo_in = {32'b0, m0_scale_ff[31:0]} * {32'b0, m0_magy_ff};
   assign m1_xhi_in = {32'b0, m0_scale_ff[46:32]} * {15'b0, m0_magx_ff};
   assign m1_yhi_in = {32'b0, m0_scale_ff[46:32]} * {15'b0, m0_magy_ff};
   assign m1_rlo_in = {31'b0, m0_scale_ff[31:0]} * {32'b0, rhw_scale_ff};
   assign m1_rhi_in = {31'b0, m0_scale_ff[46:32]} * {15'b0, rhw_scale_ff};

   // m2: combine and cap
   logic             m2_vld_ff;
   side_type         m2_side_ff;
   logic             m2_negx_ff, m2_negy_ff;
   logic [MAG_W-1:0] m2_mx_ff, m2_my_ff, m2_mx_in, m2_my_in;
   logic [31:0]      m2_rhw_ff, m2_rhw_in;
   logic [78:0]      prod_x, prod_y;
   logic [77:0]      prod_r;

   assign prod_x = {m1_xhi_ff, 32'b0} + {15'b0, m1_xlo_ff};
   assign prod_y = {m1_yhi_ff, 32'b0} + {15'b0, m1_ylo_ff};
   assign prod_r = {m1_rhi_ff, 32'b0} + {15'b0, m1_rlo_ff};

   assign m2_mx_in = (|prod_x[78:57] || (prod_x[56] && |prod_x[55:16])) ?
                     MAG_CAP : prod_x[56:16];
   assign m2_my_in = (|prod_y[78:57] || (prod_y[56] && |prod_y[55:16])) ?
                     MAG_CAP : prod_y[56:16];
   assign m2_rhw_in = (|prod_r[77:34]) ? 32'hFFFF_FFFF : prod_r[33:2];

   // m3: sign, centre offset, saturation
   logic        m3_vld_ff;
   side_type    m3_side_ff;
   logic [31:0] m3_px_ff, m3_py_ff, m3_px_in, m3_py_in, m3_rhw_ff;
   logic [42:0] mx43, my43, vx, vy;

   assign mx43 = {2'b0, m2_mx_ff};
   assign my43 = {2'b0, m2_my_ff};
   assign vx = (m2_negx_ff ? (43'd0 - mx43) : mx43) + {11'b0, center_xy_ff[15:0], 16'b0};
   assign vy = (m2_negy_ff ? (43'd0 - my43) : my43) + {11'b0, center_xy_ff[31:16], 16'b0};

   assign m3_px_in = ((vx[42:31] == '0) || (vx[42:31] == '1)) ? vx[31:0] :
                     (vx[42] ? 32'h8000_0000 : 32'h7FFF_FFFF);
   assign m3_py_in = ((vy[42:31] == '0) || (vy[42:31] == '1)) ? vy[31:0] :
                     (vy[42] ? 32'h8000_0000 : 32'h7FFF_FFFF);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         m0_vld_ff <= 1'b0;
         m1_vld_ff <= 1'b0;
         m2_vld_ff <= 1'b0;
         m3_vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff    <= {vld_ff[DIV_STEPS-1:0], req_tvalid};
         m0_vld_ff <= vld_ff[DIV_STEPS];
         m1_vld_ff <= m0_vld_ff;
         m2_vld_ff <= m1_vld_ff;
         m3_vld_ff <= m2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m0_side_ff  <= side_ff[DIV_STEPS];
         m0_scale_ff <= nq_ff[DIV_STEPS];
         m0_magx_ff  <= m0_magx_in;
         m0_magy_ff  <= m0_magy_in;
         m0_negx_ff  <= side_ff[DIV_STEPS].cam_x[31];
         m0_negy_ff  <= side_ff[DIV_STEPS].cam_y[31];
         m1_side_ff  <= m0_side_ff;
         m1_negx_ff  <= m0_negx_ff;
         m1_negy_ff  <= m0_negy_ff;
         m1_xlo_ff   <= m1_xlo_in;
         m1_ylo_ff   <= m1_ylo_in;
         m1_xhi_ff   <= m1_xhi_in;
         m1_yhi_ff   <= m1_yhi_in;
         m1_rlo_ff   <= m1_rlo_in;
         m1_rhi_ff   <= m1_rhi_in;
         m2_side_ff  <= m1_side_ff;
         m2_negx_ff  <= m1_negx_ff;
         m2_negy_ff  <= m1_negy_ff;
         m2_mx_ff    <= m2_mx_in;
         m2_my_ff    <= m2_my_in;
         m2_rhw_ff   <= m2_rhw_in;
         m3_side_ff  <= m2_side_ff;
         m3_px_ff    <= m3_px_in;
         m3_py_ff    <= m3_py_in;
         m3_rhw_ff   <= m2_rhw_ff;
      end
   end

   // outcodes and final select
   logic              out_l, out_r, out_t, out_b;
   logic [CODE_W-1:0] res_code;
   logic [31:0]       res_sx, res_sy, res_depth, res_rhw;
   logic [RSP_W-1:0]  res_data;

   assign out_l = $signed({{2{m3_px_ff[31]}}, m3_px_ff}) <
                  $signed({2'b0, clip_x_win_ff[15:0], 16'b0});
   assign out_r = $signed({{2{m3_px_ff[31]}}, m3_px_ff}) >
                  $signed({2'b0, clip_x_win_ff[31:16], 16'b0});
   assign out_t = $signed({{2{m3_py_ff[31]}}, m3_py_ff}) <
                  $signed({2'b0, clip_y_win_ff[15:0], 16'b0});
   assign out_b = $signed({{2{m3_py_ff[31]}}, m3_py_ff}) >
                  $signed({2'b0, clip_y_win_ff[31:16], 16'b0});

   always_comb begin
      if (m3_side_ff.near) begin
         res_sx    = m3_side_ff.cam_x;
         res_sy    = m3_side_ff.cam_y;
         res_depth = m3_side_ff.cam_z;
         res_rhw   = m3_side_ff.rhw_in;
         res_code  = CODE_NEAR;
      end else begin
         res_sx    = m3_px_ff;
         res_sy    = m3_py_ff;
         res_depth = m3_side_ff.far ? {1'b0, far_z_ff} : m3_side_ff.cam_z;
         res_rhw   = m3_rhw_ff;
         res_code  = {1'b0, m3_side_ff.far, 4'b0, out_b && !out_t, out_t,
                      out_r && !out_l, out_l};
      end
   end

   assign res_data = {6'b0, res_code, m3_side_ff.cam_y, m3_side_ff.cam_x,
                      res_rhw, res_depth, res_sy, res_sx};

   // output register and skid stage
   logic             push, pop;
   logic             load_from_skid, load_from_pipe, load_skid;
   logic [RSP_W-1:0] rsp_data_ff, skid_data_ff;
   logic             rsp_last_ff, skid_last_ff;

   assign push = adv && m3_vld_ff;
   assign pop  = rsp_vld_ff && rsp_tready;

   always_comb begin
      rsp_vld_in     = rsp_vld_ff;
      skid_vld_in    = skid_vld_ff;
      load_from_skid = 1'b0;
      load_from_pipe = 1'b0;
      load_skid      = 1'b0;
      if (skid_vld_ff) begin
         if (pop) begin
            load_from_skid = 1'b1;
            skid_vld_in    = 1'b0;
         end
      end else if (push) begin
         if (rsp_vld_ff && !pop) begin
            load_skid   = 1'b1;
            skid_vld_in = 1'b1;
         end else begin
            load_from_pipe = 1'b1;
            rsp_vld_in     = 1'b1;
         end
      end else if (pop) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff  <= rsp_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_from_skid) begin
         rsp_data_ff <= skid_data_ff;
         rsp_last_ff <= skid_last_ff;
      end else if (load_from_pipe) begin
         rsp_data_ff <= res_data;
         rsp_last_ff <= m3_side_ff.last;
      end
      if (load_skid) begin
         skid_data_ff <= res_data;
         skid_last_ff <= m3_side_ff.last;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> rsp_vld_ff)
      else $error("skid stage holds a result while output register is empty");

   a_div_rem_bound: assert property (@(posedge clock) disable iff (reset)
      vld_ff[DIV_STEPS] |-> (rem_ff[DIV_STEPS] < dvs_ff[DIV_STEPS]))
      else $error("divider remainder not below divisor");

   a_neg_code_near: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_data_ff[201]) |-> (rsp_data_ff[201:192] == CODE_NEAR))
      else $error("negative clip code other than near clip");

   a_outcode_excl: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !rsp_data_ff[201]) |->
         (!(rsp_data_ff[192] && rsp_data_ff[193]) && !(rsp_data_ff[194] && rsp_data_ff[195])))
      else $error("opposite outcode bits both set");
`endif

endmodule

FILE: sim/perspective_project_outcode_tb.sv
// ----------------------------------------------------------------------------
// perspective_project_outcode_tb
// Streams camera-space vertices through the projection block and checks each
// result against a bit-exact fixed-point predictor or a typed directed row.
// A short directed table comes first, then eight register settings (all-zero,
// all-ones, reset defaults, random) with bursts of random vertices and random
// gaps in most phases; one long output hold-off in phase 2 backs up the pipeline.
// ----------------------------------------------------------------------------
module perspective_project_outcode_tb
   import ppo_pkg::*;
;

   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 242;
   localparam int HOLD_CYCLES   = 300;
   localparam int DRAIN_CYCLES  = 120;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int DIRECTED_ROWS = 14;

   localparam logic [CODE_W-1:0] CODE_FAR   = 10'd256;
   localparam logic [CODE_W-1:0] OUT_LEFT   = 10'd1;
   localparam logic [CODE_W-1:0] OUT_RIGHT  = 10'd2;
   localparam logic [CODE_W-1:0] OUT_TOP    = 10'd4;
   localparam logic [CODE_W-1:0] OUT_BOTTOM = 10'd8;

   localparam longint S32_MAX = 64'sd2147483647;
   localparam longint S32_MIN = -64'sd2147483648;

   typedef struct packed {
      logic [31:0] cam_x;
      logic [31:0] cam_y;
      logic [31:0] cam_z;
      logic [31:0] rhw_in;
      logic        last;
   } vertex_type;

   typedef struct packed {
      logic [31:0]       screen_x;
      logic [31:0]       screen_y;
      logic [31:0]       depth;
      logic [31:0]       rhw;
      logic [31:0]       tex_u;
      logic [31:0]       tex_v;
      logic [CODE_W-1:0] code;
      logic              last;
   } projected_type;

   typedef struct packed {
      logic [31:0]       cam_x;
      logic [31:0]       cam_y;
      logic [31:0]       cam_z;
      logic [31:0]       rhw_in;
      logic              last;
      logic              typed;
      logic [31:0]       sx;
      logic [31:0]       sy;
      logic [31:0]       depth;
      logic [31:0]       rhw;
      logic [CODE_W-1:0] code;
   } stim_row_type;

   logic              clock;
   logic              reset       = 1'b1;
   logic              req_tvalid  = 1'b0;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata   = '0;
   logic              req_tlast   = 1'b0;
   logic              rsp_tvalid;
   logic              rsp_tready  = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;
   logic              rsp_tlast;
   logic              csr_psel    = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0] csr_paddr   = '0;
   logic [31:0]       csr_pwdata  = '0;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   logic [30:0] cfg_near_z      = RST_NEAR_Z;
   logic [30:0] cfg_fog_end     = RST_FOG_END;
   logic [30:0] cfg_far_z       = RST_FAR_Z;
   logic [30:0] cfg_persp_scale = RST_PERSP_SCALE;
   logic [30:0] cfg_rhw_scale   = RST_RHW_SCALE;
   logic [31:0] cfg_center_xy   = RST_CENTER_XY;
   logic [31:0] cfg_clip_x_win  = RST_CLIP_X_WIN;
   logic [31:0] cfg_clip_y_win  = RST_CLIP_Y_WIN;

   projected_type projected_q[$];
   int            mismatch_count = 0;
   int            result_count   = 0;
   int            cycle_count    = 0;
   bit            tx_idle_on     = 1'b1;
   bit            rx_idle_on     = 1'b1;
   bit            hold_request   = 1'b0;

   // reset settings: near clip, inside, outcodes, saturation, fog boundary
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h1234_5678, 1'b0, 1'b1,
        32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h1234_5678, CODE_NEAR},
      '{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1,
        32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, CODE_NEAR},
      '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_FFFF, 32'h0000_0000, 1'b0, 1'b1,
        32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_FFFF, 32'h0000_0000, CODE_NEAR},
      '{32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1, 1'b1,
        32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000, CODE_NEAR},
      '{32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 32'h0000_0000, 1'b0, 1'b0,
        32'h0, 32'h0, 32'h0, 32'h0, '0},
      '{32'h0001_0000, 32'h0000_0000, 32'h0001_0000, 32'h0000_0000, 1'b0, 1'b0,
        32'h0, 32'h0, 32'h0, 32'h0, '0},
      '{32'hFFFF_0000, 32'h0000_0000, 32'h0001_0000, 32'h0000_0000, 1'b0, 1'b0,
        32'h0, 32'h0, 32'h0, 32'h0, '0},
      '{32'h0000_0000, 32'hFFFF_0000, 32'h0001_0000, 32'h0000_0000, 1'b0, 1'b0,
        32'h0, 32'h0, 32'h0, 32'h0, '0},
      '{32'h0000_0000, 32'h0001_0000, 32'h0001_0000, 32'h0000_0000, 1'b1, 1'b0,
        32'h0, 32'h0, 32'h0, 32'h0, '0},
      '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'h0000_0000, 1'b1, 1'b1,
        32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'hFFFF_FFFF, OUT_RIGHT | OUT_TOP},
      '{32'h0000_0000, 32'h0000_0000, 32'h5000_0000, 32'h0000_0000, 1'b0, 1'b0,
        32'h0, 32'h0, 32'h0, 32'h0, '0},
      '{32'h0000_0000, 32'h0000_0000, 32'h5000_0001, 32'h0000_0000, 1'b0, 1'b0,
        32'h0, 32'h0, 32'h0, 32'h0, '0},
      '{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b0,
        32'h0, 32'h0, 32'h0, 32'h0, '0},
      '{32'h0000_1234, 32'hFFFF_EDCB, 32'h4000_0000, 32'h0000_0000, 1'b0, 1'b0,
        32'h0, 32'h0, 32'h0, 32'h0, '0}
   };

   perspective_project_outcode dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("perspective_project_outcode_tb NOT OK");
         $finish;
      end
   end

   // one screen axis: truncated magnitude product, signed, centred, saturated
   function automatic longint to_screen(input logic [31:0] coord,
                                        input longint unsigned scale,
                                        input logic [15:0] centre_px);
      longint unsigned mag, hi, m;
      longint          v;
      mag = coord[31] ? 64'h1_0000_0000 - coord : {32'd0, coord};
      hi  = (scale >> 32) * mag;
      if (hi >= 64'h1_0000_0000) begin
         m = MAG_CAP;
      end else begin
         m = (hi << 16) + (((scale & 64'hFFFF_FFFF) * mag) >> 16);
         if (m > MAG_CAP) m = MAG_CAP;
      end
      v = coord[31] ? -longint'(m) : longint'(m);
      v = v + (longint'(centre_px) <<< 16);
      if (v > S32_MAX) v = S32_MAX;
      if (v < S32_MIN) v = S32_MIN;
      return v;
   endfunction

   function automatic projected_type project_vertex(input vertex_type v);
      projected_type   r;
      longint          z, px, py;
      longint unsigned zd, scale;
      r.tex_u = v.cam_x;
      r.tex_v = v.cam_y;
      r.last  = v.last;
      z = longint'(signed'(v.cam_z));
      if (z < longint'(cfg_near_z)) begin
         r.screen_x = v.cam_x;
         r.screen_y = v.cam_y;
         r.depth    = v.cam_z;
         r.rhw      = v.rhw_in;
         r.code     = CODE_NEAR;
      end else begin
         zd    = (z == 0) ? 64'd1 : z;
         scale = {17'd0, cfg_persp_scale, 16'd0} / zd;
         r.code = '0;
         if (z > longint'(cfg_fog_end)) begin
            r.depth = {1'b0, cfg_far_z};
            r.code  = CODE_FAR;
         end else begin
            r.depth = v.cam_z;
         end
         px = to_screen(v.cam_x, scale, cfg_center_xy[15:0]);
         py = to_screen(v.cam_y, scale, cfg_center_xy[31:16]);
         if (cfg_rhw_scale == 0)
            r.rhw = '0;
         else if (scale > (64'h3_FFFF_FFFF / cfg_rhw_scale))
            r.rhw = '1;
         else
            r.rhw = 32'((scale * cfg_rhw_scale) >> 2);
         if (px < longint'({cfg_clip_x_win[15:0], 16'd0}))
            r.code = r.code | OUT_LEFT;
         else if (px > longint'({cfg_clip_x_win[31:16], 16'd0}))
            r.code = r.code | OUT_RIGHT;
         if (py < longint'({cfg_clip_y_win[15:0], 16'd0}))
            r.code = r.code | OUT_TOP;
         else if (py > longint'({cfg_clip_y_win[31:16], 16'd0}))
            r.code = r.code | OUT_BOTTOM;
         r.screen_x = px[31:0];
         r.screen_y = py[31:0];
      end
      return r;
   endfunction

   function automatic int pick_gap(input bit enable);
      int r;
      r = $urandom_range(99);
      if (!enable || r < 65) return 0;
      if (r < 95) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   function automatic logic [31:0] pick_coord();
      logic [31:0] m;
      case ($urandom_range(5))
         0, 1: return $urandom;
         2: begin
            case ($urandom_range(3))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'h0000_0000;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         default: begin
            m = $urandom_range((32'h1 << $urandom_range(30, 8)) - 32'h1);
            return $urandom_range(1) ? -m : m;
         end
      endcase
   endfunction

   function automatic logic [31:0] pick_depth();
      logic [31:0] near_w, fog_w;
      near_w = {1'b0, cfg_near_z};
      fog_w  = {1'b0, cfg_fog_end};
      case ($urandom_range(11))
         0: return near_w;
         1: return near_w - 32'd1;
         2: return fog_w;
         3: return fog_w + 32'd1;
         4: return 32'd0;
         5: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         6, 7: return $urandom;
         8: return $urandom_range(32'h7FFF_FFFF, fog_w);
         default: return $urandom_range(fog_w, near_w);
      endcase
   endfunction

   function automatic vertex_type random_vertex();
      vertex_type v;
      v.cam_x  = pick_coord();
      v.cam_y  = pick_coord();
      v.cam_z  = pick_depth();
      v.rhw_in = $urandom;
      v.last   = ($urandom_range(15) == 0);
      return v;
   endfunction

   function automatic logic [31:0] pick_setting(input logic [31:0] hi, input logic [31:0] lo);
      return $urandom_range(1) ? $urandom_range(hi, lo) : $urandom;
   endfunction

   function automatic logic [31:0] pick_window();
      return $urandom_range(1) ? {16'($urandom_range(4000, 200)), 16'($urandom_range(200))}
                               : $urandom;
   endfunction

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      $display("mismatch at %0t, vertex %0d: %s got %h expected %h",
               $time, result_count, what, got, want);
      mismatch_count++;
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_NEAR_Z:      cfg_near_z      = value[30:0];
         REG_FOG_END:     cfg_fog_end     = value[30:0];
         REG_FAR_Z:       cfg_far_z       = value[30:0];
         REG_PERSP_SCALE: cfg_persp_scale = value[30:0];
         REG_RHW_SCALE:   cfg_rhw_scale   = value[30:0];
         REG_CENTER_XY:   cfg_center_xy   = value;
         REG_CLIP_X_WIN:  cfg_clip_x_win  = value;
         REG_CLIP_Y_WIN:  cfg_clip_y_win  = value;
         default: ;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic load_settings(input logic [31:0] near_v, fog_v, far_v, persp_v,
                                input logic [31:0] rhw_v, centre_v, xwin_v, ywin_v);
      csr_write(REG_NEAR_Z, near_v);
      csr_write(REG_FOG_END, fog_v);
      csr_write(REG_FAR_Z, far_v);
      csr_write(REG_PERSP_SCALE, persp_v);
      csr_write(REG_RHW_SCALE, rhw_v);
      csr_write(REG_CENTER_XY, centre_v);
      csr_write(REG_CLIP_X_WIN, xwin_v);
      csr_write(REG_CLIP_Y_WIN, ywin_v);
   endtask

   // called at a falling edge, returns at the falling edge after the transaction
   task automatic send_vertex(input vertex_type v, input bit typed,
                              input projected_type typed_result);
      int gap;
      gap = pick_gap(tx_idle_on);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {v.rhw_in, v.cam_z, v.cam_y, v.cam_x};
      req_tlast  <= v.last;
      do @(posedge clock); while (!req_tready);
      if (typed)
         projected_q.push_back(typed_result);
      else
         projected_q.push_back(project_vertex(v));
      @(negedge clock);
   endtask

   initial begin : rsp_sink
      int stall_left;
      bit hold_done;
      stall_left = 0;
      hold_done  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_done) begin
            hold_done  = 1'b1;
            stall_left = HOLD_CYCLES;
         end else if (stall_left == 0) begin
            stall_left = pick_gap(rx_idle_on);
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      projected_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (projected_q.size() == 0) begin
            flag_mismatch("transaction with nothing pending", rsp_tdata[31:0], 32'h0);
         end else begin
            want = projected_q.pop_front();
            if (rsp_tdata[31:0] !== want.screen_x)
               flag_mismatch("screen_x", rsp_tdata[31:0], want.screen_x);
            if (rsp_tdata[63:32] !== want.screen_y)
               flag_mismatch("screen_y", rsp_tdata[63:32], want.screen_y);
            if (rsp_tdata[95:64] !== want.depth)
               flag_mismatch("depth_out", rsp_tdata[95:64], want.depth);
            if (rsp_tdata[127:96] !== want.rhw)
               flag_mismatch("rhw_out", rsp_tdata[127:96], want.rhw);
            if (rsp_tdata[159:128] !== want.tex_u)
               flag_mismatch("tex_u", rsp_tdata[159:128], want.tex_u);
            if (rsp_tdata[191:160] !== want.tex_v)
               flag_mismatch("tex_v", rsp_tdata[191:160], want.tex_v);
            if (rsp_tdata[201:192] !== want.code)
               flag_mismatch("clip_code", {22'd0, rsp_tdata[201:192]}, {22'd0, want.code});
            if (rsp_tlast !== want.last)
               flag_mismatch("last_out", {31'd0, rsp_tlast}, {31'd0, want.last});
         end
         result_count++;
      end
   end

   initial begin : stimulus
      stim_row_type  row;
      vertex_type    v;
      projected_type typed_result;
      int            phase, n;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (n = 0; n < DIRECTED_ROWS; n++) begin
         row = directed_rows[n];
         v.cam_x  = row.cam_x;
         v.cam_y  = row.cam_y;
         v.cam_z  = row.cam_z;
         v.rhw_in = row.rhw_in;
         v.last   = row.last;
         typed_result.screen_x = row.sx;
         typed_result.screen_y = row.sy;
         typed_result.depth    = row.depth;
         typed_result.rhw      = row.rhw;
         typed_result.tex_u    = row.cam_x;
         typed_result.tex_v    = row.cam_y;
         typed_result.code     = row.code;
         typed_result.last     = row.last;
         send_vertex(v, row.typed, typed_result);
      end

      for (phase = 0; phase < PHASES; phase++) begin
         req_tvalid <= 1'b0;
         while (projected_q.size() != 0) @(negedge clock);
         tx_idle_on = (phase != 3);
         rx_idle_on = (phase != 3) && (phase != 6);
         case (phase)
            0: load_settings('0, '0, '0, '0, '0, '0, '0, '0);
            1: load_settings('1, '1, '1, '1, '1, '1, '1, '1);
            3: load_settings({1'b0, RST_NEAR_Z}, {1'b0, RST_FOG_END}, {1'b0, RST_FAR_Z},
                             {1'b0, RST_PERSP_SCALE}, {1'b0, RST_RHW_SCALE},
                             RST_CENTER_XY, RST_CLIP_X_WIN, RST_CLIP_Y_WIN);
            default: load_settings(phase == 2 ? 32'h0 : pick_setting(32'h0004_0000, 32'h0),
                                   pick_setting(32'h7FFF_FFFF, 32'h0010_0000),
                                   $urandom,
                                   pick_setting(32'h0800_0000, 32'h0004_0000),
                                   pick_setting(32'h0010_0000, 32'h0000_0100),
                                   pick_window(), pick_window(), pick_window());
         endcase
         for (n = 0; n < PHASE_ITEMS; n++) begin
            // long output hold-off so the pipeline fills and stalls the input
            if (phase == 2 && n == 40) hold_request = 1'b1;
            send_vertex(random_vertex(), 1'b0, '0);
         end
      end

      req_tvalid <= 1'b0;
      while (projected_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("perspective_project_outcode_tb OK");
      else
         $display("perspective_project_outcode_tb NOT OK");
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/ppo_pkg.sv
hw/rtl/perspective_project_outcode.sv
sim/perspective_project_outcode_tb.sv
